/* hw/rtl/fma_pkg.sv */
// shared types, constants and character codes for the format mask apply unit
`default_nettype none
package fma_pkg;

	// default sizes
	localparam int SOURCE_DEPTH_DEF = 64;
	localparam int CHAR_WIDTH_DEF   = 16;
	localparam int CMDQ_DEPTH       = 2;
	localparam int OUTQ_DEPTH       = 2;

	// input operation codes
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_MASK   = 2'd2;

	// mask character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_X      = 8'h58;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	// ascii class bounds on the low seven bits
	localparam logic [6:0] ASC_UP_LO  = 7'h41;
	localparam logic [6:0] ASC_UP_HI  = 7'h5A;
	localparam logic [6:0] ASC_LOW_LO = 7'h61;
	localparam logic [6:0] ASC_LOW_HI = 7'h7A;
	localparam logic [6:0] ASC_DIG_LO = 7'h30;
	localparam logic [6:0] ASC_DIG_HI = 7'h39;

	// bit that separates upper and lower case letters
	localparam int CASE_BIT = 5;

	typedef enum logic [1:0] {
		MODE_PRESERVE = 2'd0,
		MODE_UPPER    = 2'd1,
		MODE_LOWER    = 2'd2
	} case_mode_t;

	// commands from the front to the back
	typedef enum logic [2:0] {
		CMD_START  = 3'd0,
		CMD_APPEND = 3'd1,
		CMD_LIT    = 3'd2,
		CMD_QMARK  = 3'd3,
		CMD_ALNUM  = 3'd4,
		CMD_ALPHA  = 3'd5,
		CMD_DIGIT  = 3'd6,
		CMD_STAR   = 3'd7
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		case_mode_t mode;
	} cmd_ctl_t;

	// back sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} back_state_t;

endpackage
`default_nettype wire

/* hw/rtl/fma_fifo.sv */
// small register fifo used for the command queue and the result queue
`default_nettype none
module fma_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/fma_front.sv */
// front end: accepts items, tracks escape and case mode, classifies mask characters
`default_nettype none
module fma_front #(
	parameter int CHAR_WIDTH = fma_pkg::CHAR_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            operation,
	input  wire logic [CHAR_WIDTH-1:0] character,
	input  wire logic                  cmdq_full,
	output logic                       cmd_push,
	output fma_pkg::cmd_ctl_t          cmd_ctl
);
	logic                escape_q;
	fma_pkg::case_mode_t mode_q;
	logic                escape_d;
	fma_pkg::case_mode_t mode_d;
	logic                cmd_valid;
	logic                accept;

	assign full   = cmdq_full;
	assign accept = push && !cmdq_full;

	// classify the item and work out the next escape and case state
	always_comb begin
		escape_d     = escape_q;
		mode_d       = mode_q;
		cmd_valid    = 1'b0;
		cmd_ctl.kind = fma_pkg::CMD_LIT;
		cmd_ctl.mode = mode_q;
		case (operation)
			fma_pkg::OP_START: begin
				escape_d     = 1'b0;
				mode_d       = fma_pkg::MODE_PRESERVE;
				cmd_valid    = 1'b1;
				cmd_ctl.kind = fma_pkg::CMD_START;
			end
			fma_pkg::OP_APPEND: begin
				cmd_valid    = 1'b1;
				cmd_ctl.kind = fma_pkg::CMD_APPEND;
			end
			fma_pkg::OP_MASK: begin
				cmd_valid = 1'b1;
				if (escape_q) begin
					escape_d     = 1'b0;
					cmd_ctl.kind = fma_pkg::CMD_LIT;
				end else if (character == CHAR_WIDTH'(fma_pkg::CH_BSLASH)) begin
					escape_d  = 1'b1;
					cmd_valid = 1'b0;
				end else if (character == CHAR_WIDTH'(fma_pkg::CH_LT)) begin
					mode_d    = fma_pkg::MODE_LOWER;
					cmd_valid = 1'b0;
				end else if (character == CHAR_WIDTH'(fma_pkg::CH_GT)) begin
					mode_d    = fma_pkg::MODE_UPPER;
					cmd_valid = 1'b0;
				end else if (character == CHAR_WIDTH'(fma_pkg::CH_EQ)) begin
					mode_d    = fma_pkg::MODE_PRESERVE;
					cmd_valid = 1'b0;
				end else if (character == CHAR_WIDTH'(fma_pkg::CH_QMARK)) begin
					cmd_ctl.kind = fma_pkg::CMD_QMARK;
				end else if (character == CHAR_WIDTH'(fma_pkg::CH_X)) begin
					cmd_ctl.kind = fma_pkg::CMD_ALNUM;
				end else if (character == CHAR_WIDTH'(fma_pkg::CH_A)) begin
					cmd_ctl.kind = fma_pkg::CMD_ALPHA;
				end else if (character == CHAR_WIDTH'(fma_pkg::CH_NINE)) begin
					cmd_ctl.kind = fma_pkg::CMD_DIGIT;
				end else if (character == CHAR_WIDTH'(fma_pkg::CH_STAR)) begin
					cmd_ctl.kind = fma_pkg::CMD_STAR;
				end else begin
					cmd_ctl.kind = fma_pkg::CMD_LIT;
				end
			end
			default: begin
				cmd_valid = 1'b0;
			end
		endcase
	end

	assign cmd_push = accept && cmd_valid;

	// escape flag and case mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
			mode_q   <= fma_pkg::MODE_PRESERVE;
		end else if (accept) begin
			escape_q <= escape_d;
			mode_q   <= mode_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/fma_back.sv */
// back end: source buffer, read position and the sequencer that emits result characters
`default_nettype none
module fma_back #(
	parameter int SOURCE_DEPTH = fma_pkg::SOURCE_DEPTH_DEF,
	parameter int CHAR_WIDTH   = fma_pkg::CHAR_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_empty,
	input  wire fma_pkg::cmd_ctl_t     cmd_ctl,
	input  wire logic [CHAR_WIDTH-1:0] cmd_char,
	output logic                       cmd_pop,
	input  wire logic                  out_full,
	output logic                       out_push,
	output logic      [CHAR_WIDTH-1:0] out_char,
	output logic                       out_last
);
	localparam int AW = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;
	localparam int LW = $clog2(SOURCE_DEPTH + 1);

	logic [CHAR_WIDTH-1:0] mem [SOURCE_DEPTH];
	logic [CHAR_WIDTH-1:0] rdata_q;
	logic [LW-1:0]         len_q;
	logic [LW-1:0]         rpos_q;
	fma_pkg::back_state_t  state_q;

	logic [LW-1:0]         len_d;
	logic [LW-1:0]         rpos_d;
	fma_pkg::back_state_t  state_d;
	logic                  we;
	logic                  re;
	logic [AW-1:0]         raddr;
	logic [LW-1:0]         rpos_inc;

	// character classes of the fetched source character
	logic                  hi_zero;
	logic [6:0]            low7;
	logic                  is_up;
	logic                  is_low;
	logic                  is_dig;
	logic                  hit;
	logic                  finish;
	logic [CHAR_WIDTH-1:0] trans;

	assign hi_zero  = (rdata_q >> 7) == '0;
	assign low7     = rdata_q[6:0];
	assign is_up    = hi_zero && (low7 inside {[fma_pkg::ASC_UP_LO:fma_pkg::ASC_UP_HI]});
	assign is_low   = hi_zero && (low7 inside {[fma_pkg::ASC_LOW_LO:fma_pkg::ASC_LOW_HI]});
	assign is_dig   = hi_zero && (low7 inside {[fma_pkg::ASC_DIG_LO:fma_pkg::ASC_DIG_HI]});
	assign rpos_inc = rpos_q + 1'b1;

	// case translation of ascii letters
	always_comb begin
		trans = rdata_q;
		if ((cmd_ctl.mode == fma_pkg::MODE_LOWER && is_up) ||
			(cmd_ctl.mode == fma_pkg::MODE_UPPER && is_low)) begin
			trans[fma_pkg::CASE_BIT] = ~rdata_q[fma_pkg::CASE_BIT];
		end
	end

	// match of the fetched character against the command's class
	always_comb begin
		case (cmd_ctl.kind)
			fma_pkg::CMD_ALNUM: hit = is_up || is_low || is_dig;
			fma_pkg::CMD_ALPHA: hit = is_up || is_low;
			fma_pkg::CMD_DIGIT: hit = is_dig;
			default:            hit = 1'b1;
		endcase
		finish = (hit && cmd_ctl.kind != fma_pkg::CMD_STAR) || (rpos_inc == len_q);
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		rpos_d   = rpos_q;
		we       = 1'b0;
		re       = 1'b0;
		raddr    = rpos_q[AW-1:0];
		cmd_pop  = 1'b0;
		out_push = 1'b0;
		out_char = cmd_char;
		out_last = 1'b1;
		case (state_q)
			fma_pkg::ST_IDLE: begin
				if (!cmd_empty) begin
					case (cmd_ctl.kind)
						fma_pkg::CMD_START: begin
							cmd_pop = 1'b1;
							len_d   = '0;
							rpos_d  = '0;
						end
						fma_pkg::CMD_APPEND: begin
							cmd_pop = 1'b1;
							if (len_q < LW'(SOURCE_DEPTH)) begin
								we    = 1'b1;
								len_d = len_q + 1'b1;
							end
						end
						fma_pkg::CMD_LIT: begin
							if (!out_full) begin
								cmd_pop  = 1'b1;
								out_push = 1'b1;
							end
						end
						default: begin
							// source reading command: fetch first character or finish
							if (rpos_q < len_q) begin
								re      = 1'b1;
								state_d = fma_pkg::ST_RUN;
							end else begin
								cmd_pop = 1'b1;
							end
						end
					endcase
				end
			end
			fma_pkg::ST_RUN: begin
				// one source character consumed per cycle unless the result queue stalls
				out_char = trans;
				out_last = finish;
				if (!hit || !out_full) begin
					out_push = hit;
					rpos_d   = rpos_inc;
					if (finish) begin
						cmd_pop = 1'b1;
						state_d = fma_pkg::ST_IDLE;
					end else begin
						re    = 1'b1;
						raddr = rpos_inc[AW-1:0];
					end
				end
			end
			default: begin
				state_d = fma_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fma_pkg::ST_IDLE;
			len_q   <= '0;
			rpos_q  <= '0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			rpos_q  <= rpos_d;
		end
	end

	// source buffer with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[len_q[AW-1:0]] <= cmd_char;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/format_mask_apply_unit.sv */
// top level: front end, command queue, back end and result queue
// a literal mask character passes through the command queue and the back end to the
// result queue; a source reading one examines source characters one at a time.
// throughput: the front takes one item per cycle while the command queue has room;
// the back end retires other commands one per cycle, literals while the result queue
// has room; source reading commands take one character per cycle unless stalled.
// reset clears queues, lengths, positions, case mode and escape; buffer data is kept.
`default_nettype none
module format_mask_apply_unit #(
	parameter int SOURCE_DEPTH = fma_pkg::SOURCE_DEPTH_DEF,
	parameter int CHAR_WIDTH   = fma_pkg::CHAR_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            operation,
	input  wire logic [CHAR_WIDTH-1:0] character,
	output logic                       empty,
	input  wire logic                  pop,
	output logic      [CHAR_WIDTH-1:0] out_char,
	output logic                       last_of_run
);
	localparam int CTL_W = $bits(fma_pkg::cmd_ctl_t);
	localparam int CMD_W = CTL_W + CHAR_WIDTH;
	localparam int RES_W = CHAR_WIDTH + 1;

	logic                  cmdq_full;
	logic                  cmdq_empty;
	logic                  cmd_push;
	logic                  cmd_pop;
	fma_pkg::cmd_ctl_t     front_ctl;
	fma_pkg::cmd_ctl_t     head_ctl;
	logic [CHAR_WIDTH-1:0] head_char;
	logic [CMD_W-1:0]      cmdq_rdata;

	logic                  outq_full;
	logic                  res_push;
	logic [CHAR_WIDTH-1:0] res_char;
	logic                  res_last;
	logic [RES_W-1:0]      outq_rdata;

	// classification front
	fma_front #(
		.CHAR_WIDTH (CHAR_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.character (character),
		.cmdq_full (cmdq_full),
		.cmd_push  (cmd_push),
		.cmd_ctl   (front_ctl)
	);

	// command queue between front and back
	fma_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (fma_pkg::CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  ({front_ctl, character}),
		.full   (cmdq_full),
		.pop    (cmd_pop),
		.rdata  (cmdq_rdata),
		.empty  (cmdq_empty)
	);

	assign head_ctl  = fma_pkg::cmd_ctl_t'(cmdq_rdata[CMD_W-1:CHAR_WIDTH]);
	assign head_char = cmdq_rdata[CHAR_WIDTH-1:0];

	// execution back
	fma_back #(
		.SOURCE_DEPTH (SOURCE_DEPTH),
		.CHAR_WIDTH   (CHAR_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmdq_empty),
		.cmd_ctl   (head_ctl),
		.cmd_char  (head_char),
		.cmd_pop   (cmd_pop),
		.out_full  (outq_full),
		.out_push  (res_push),
		.out_char  (res_char),
		.out_last  (res_last)
	);

	// result queue
	fma_fifo #(
		.WIDTH (RES_W),
		.DEPTH (fma_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  ({res_char, res_last}),
		.full   (outq_full),
		.pop    (pop),
		.rdata  (outq_rdata),
		.empty  (empty)
	);

	assign out_char    = outq_rdata[RES_W-1:1];
	assign last_of_run = outq_rdata[0];

endmodule
`default_nettype wire

/* tb/tb_format_mask_apply_unit.sv */
// self-checking testbench for format_mask_apply_unit with a scoreboard class
`timescale 1ns / 100ps

// one emitted character as the block should present it
typedef struct packed {
	logic [15:0] code;
	logic        last;
} emitted_char_t;

// mask application predictor and store of expected characters
class mask_result_board;
	localparam int DEPTH = 64;

	logic [15:0]          src_buf [DEPTH];
	int unsigned          src_len;
	int unsigned          rd_pos;
	fma_pkg::case_mode_t  mode;
	bit                   esc;
	emitted_char_t        pending [$];
	int unsigned          errors;
	int unsigned          checked;
	int unsigned          dropped;

	function new();
		src_len = 0;
		rd_pos  = 0;
		mode    = fma_pkg::MODE_PRESERVE;
		esc     = 1'b0;
		errors  = 0;
		checked = 0;
		dropped = 0;
	endfunction

	function bit is_up(logic [15:0] c);
		return c >= fma_pkg::ASC_UP_LO && c <= fma_pkg::ASC_UP_HI;
	endfunction

	function bit is_low(logic [15:0] c);
		return c >= fma_pkg::ASC_LOW_LO && c <= fma_pkg::ASC_LOW_HI;
	endfunction

	function bit is_num(logic [15:0] c);
		return c >= fma_pkg::ASC_DIG_LO && c <= fma_pkg::ASC_DIG_HI;
	endfunction

	// case translation on ascii letters only
	function logic [15:0] fold_case(logic [15:0] c);
		if (mode == fma_pkg::MODE_LOWER && is_up(c))
			return c | (16'd1 << fma_pkg::CASE_BIT);
		if (mode == fma_pkg::MODE_UPPER && is_low(c))
			return c & ~(16'd1 << fma_pkg::CASE_BIT);
		return c;
	endfunction

	// update the state for one accepted item and queue what it emits
	function void note_item(logic [1:0] op, logic [15:0] ch);
		logic [15:0] run [$];
		logic [15:0] c;
		bit          hit;
		int          cls;
		cls = -1;
		case (op)
			fma_pkg::OP_START: begin
				src_len = 0;
				rd_pos  = 0;
				mode    = fma_pkg::MODE_PRESERVE;
				esc     = 1'b0;
			end
			fma_pkg::OP_APPEND: begin
				if (src_len < DEPTH) begin
					src_buf[src_len] = ch;
					src_len++;
				end else begin
					dropped++;
				end
			end
			fma_pkg::OP_MASK: begin
				if (esc) begin
					esc = 1'b0;
					run.insert(run.size(), ch);
				end else if (ch == fma_pkg::CH_BSLASH) begin
					esc = 1'b1;
				end else if (ch == fma_pkg::CH_LT) begin
					mode = fma_pkg::MODE_LOWER;
				end else if (ch == fma_pkg::CH_GT) begin
					mode = fma_pkg::MODE_UPPER;
				end else if (ch == fma_pkg::CH_EQ) begin
					mode = fma_pkg::MODE_PRESERVE;
				end else if (ch == fma_pkg::CH_QMARK) begin
					if (rd_pos < src_len) begin
						run.insert(run.size(), fold_case(src_buf[rd_pos]));
						rd_pos++;
					end
				end else if (ch == fma_pkg::CH_X) begin
					cls = 0;
				end else if (ch == fma_pkg::CH_A) begin
					cls = 1;
				end else if (ch == fma_pkg::CH_NINE) begin
					cls = 2;
				end else if (ch == fma_pkg::CH_STAR) begin
					while (rd_pos < src_len) begin
						run.insert(run.size(), fold_case(src_buf[rd_pos]));
						rd_pos++;
					end
				end else begin
					run.insert(run.size(), ch);
				end
				// scan for the next character of the wanted class
				if (cls >= 0) begin
					hit = 1'b0;
					while (!hit && rd_pos < src_len) begin
						c = src_buf[rd_pos];
						rd_pos++;
						case (cls)
							0:       hit = is_up(c) || is_low(c) || is_num(c);
							1:       hit = is_up(c) || is_low(c);
							default: hit = is_num(c);
						endcase
						if (hit)
							run.insert(run.size(), cls == 2 ? c : fold_case(c));
					end
				end
				foreach (run[i])
					pending.insert(pending.size(),
						emitted_char_t'{code: run[i], last: (i == run.size() - 1)});
			end
			default: ;
		endcase
	endfunction

	task report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// compare one result transfer with the oldest expected character
	task check_result(logic [15:0] code, logic last);
		emitted_char_t want;
		if (pending.size() == 0) begin
			report_mismatch($sformatf("result %h with nothing expected", code));
			return;
		end
		want = pending.pop_front();
		checked++;
		if (code !== want.code)
			report_mismatch($sformatf("out_char %h, expected %h", code, want.code));
		if (last !== want.last)
			report_mismatch($sformatf("last_of_run %b, expected %b for %h",
				last, want.last, want.code));
	endtask
endclass

module tb_format_mask_apply_unit;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_ITEMS = 370;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  operation;
	logic [15:0] character;
	logic        empty;
	logic        pop;
	logic [15:0] out_char;
	logic        last_of_run;

	mask_result_board board;
	int unsigned items_sent;
	int unsigned full_stalls;
	int unsigned long_holds;
	bit          hold_req;
	bit          sender_burst;

	format_mask_apply_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.character   (character),
		.empty       (empty),
		.pop         (pop),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 20);
	endfunction

	// source characters, biased towards ascii classes
	function automatic logic [15:0] source_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return ($urandom_range(0, 1) ? 16'h0041 : 16'h0061) + 16'($urandom_range(0, 25));
		if (r < 45)
			return 16'h0030 + 16'($urandom_range(0, 9));
		if (r < 70)
			return 16'($urandom_range(16'h20, 16'h7E));
		if (r < 85)
			return {8'($urandom_range(1, 255)), 8'($urandom_range(16'h30, 16'h7A))};
		return 16'($urandom);
	endfunction

	// mask characters, biased towards the special ones
	function automatic logic [15:0] mask_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return 16'(fma_pkg::CH_BSLASH);
		if (r < 17) return 16'(fma_pkg::CH_LT);
		if (r < 24) return 16'(fma_pkg::CH_GT);
		if (r < 30) return 16'(fma_pkg::CH_EQ);
		if (r < 48) return 16'(fma_pkg::CH_QMARK);
		if (r < 58) return 16'(fma_pkg::CH_X);
		if (r < 66) return 16'(fma_pkg::CH_A);
		if (r < 74) return 16'(fma_pkg::CH_NINE);
		if (r < 80) return 16'(fma_pkg::CH_STAR);
		if (r < 92) return 16'($urandom_range(16'h20, 16'h7E));
		return 16'($urandom);
	endfunction

	// offer one item and hold it until the transfer
	task automatic send_item(logic [1:0] op, logic [15:0] ch);
		int unsigned gap;
		push      <= 1'b1;
		operation <= op;
		character <= ch;
		do @(posedge clk); while (full !== 1'b0);
		if (op != OP_UNUSED)
			items_sent++;
		gap = sender_burst ? 0 : idle_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering until every expected character has come back
	task automatic drain_results();
		push <= 1'b0;
		do @(posedge clk); while (board.pending.size() != 0);
	endtask

	// one job: usually a start, source characters, then mask characters with some noise
	task automatic run_job(bit fill_buffer);
		int unsigned n_src;
		int unsigned n_mask;
		int unsigned r;
		sender_burst = ($urandom_range(0, 3) == 0);
		r = $urandom_range(0, 99);
		if (fill_buffer)
			n_src = $urandom_range(66, 72);
		else if (r < 70)
			n_src = $urandom_range(0, 8);
		else if (r < 95)
			n_src = $urandom_range(9, 40);
		else
			n_src = $urandom_range(60, 70);
		n_mask = $urandom_range(1, 14);
		// a few jobs go on from the previous one without a start
		if (fill_buffer || $urandom_range(0, 9) != 0)
			send_item(fma_pkg::OP_START, 16'($urandom));
		repeat (n_src)
			send_item(fma_pkg::OP_APPEND, source_char());
		repeat (n_mask) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				send_item(OP_UNUSED, 16'($urandom));
			else if (r < 8)
				send_item(fma_pkg::OP_APPEND, source_char());
			else
				send_item(fma_pkg::OP_MASK, mask_char());
		end
		if (fill_buffer)
			send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_STAR));
	endtask

	// transfer monitor: check results, then note accepted items and count input stalls
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (pop === 1'b1 && empty === 1'b0)
				board.check_result(out_char, last_of_run);
			if (push === 1'b1 && full === 1'b0)
				board.note_item(operation, character);
			if (push === 1'b1 && full === 1'b1)
				full_stalls++;
		end
	end

	// result side: random stalls, calm stretches and one long hold on request
	initial begin
		int unsigned gap;
		int unsigned calm;
		calm = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				long_holds++;
				gap = LONG_HOLD;
			end else if (calm != 0) begin
				calm--;
				gap = 0;
			end else begin
				gap = idle_gap();
				if ($urandom_range(0, 29) == 0)
					calm = $urandom_range(20, 60);
			end
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
		end
	end

	// run limit
	initial begin
		#25_000_000;
		$display("tb: failure");
		$finish;
	end

	// stimulus
	initial begin
		int unsigned jobs;
		board        = new();
		items_sent   = 0;
		full_stalls  = 0;
		long_holds   = 0;
		hold_req     = 1'b0;
		sender_burst = 1'b0;
		jobs         = 0;
		arst_n    <= 1'b0;
		push      <= 1'b0;
		operation <= fma_pkg::OP_START;
		character <= 16'h0000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// source reading masks straight after reset find nothing
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_QMARK));
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_X));
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_STAR));
		send_item(OP_UNUSED, 16'hFFFF);
		// source: a B - 5, a non-letter with the low byte of A, q, all ones
		send_item(fma_pkg::OP_START, 16'hFFFF);
		send_item(fma_pkg::OP_APPEND, 16'h0061);
		send_item(fma_pkg::OP_APPEND, 16'h0042);
		send_item(fma_pkg::OP_APPEND, 16'h002D);
		send_item(fma_pkg::OP_APPEND, 16'h0035);
		send_item(fma_pkg::OP_APPEND, 16'h0141);
		send_item(fma_pkg::OP_APPEND, 16'h0071);
		send_item(fma_pkg::OP_APPEND, 16'hFFFF);
		// upper case copy, digit scan, letter scan past the wide character
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_GT));
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_QMARK));
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_LT));
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_NINE));
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_A));
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_EQ));
		// escaped backslash and escaped star come out literally
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_BSLASH));
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_BSLASH));
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_BSLASH));
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_STAR));
		// plain literals at both ends of the range, then a scan that runs dry
		send_item(fma_pkg::OP_MASK, 16'h0000);
		send_item(fma_pkg::OP_MASK, 16'hFFFF);
		send_item(fma_pkg::OP_MASK, 16'(fma_pkg::CH_X));
		drain_results();

		// long receiver hold while literals keep coming, so the input stalls
		hold_req = 1'b1;
		sender_burst = 1'b1;
		repeat (16)
			send_item(fma_pkg::OP_MASK, 16'h0023);
		drain_results();

		// random jobs, the first one overfilling the source buffer
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			run_job(jobs == 0);
			jobs++;
			if (jobs % 12 == 0)
				drain_results();
		end

		// wait for the last results and allow for a trailing scan
		drain_results();
		repeat (200) @(posedge clk);
		if (board.pending.size() != 0)
			board.report_mismatch($sformatf("%0d results never came",
				board.pending.size()));

		$display("summary: %0d jobs, %0d results checked, %0d appends dropped at full buffer",
			jobs, board.checked, board.dropped);
		$display("summary: %0d input stall cycles, %0d long output holds, %0d mismatches",
			full_stalls, long_holds, board.errors);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
